[src/sunshade_roll_controller_core_defines.svh]
// Assertion macros shared by the sunshade roll controller RTL.
// Depends on nothing; set ASSERT_OFF to compile the checks out.
`ifndef SUNSHADE_ROLL_CONTROLLER_CORE_DEFINES_SVH
`define SUNSHADE_ROLL_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define SRCTL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("srctl assertion failed");
// expr must never be true outside reset
`define SRCTL_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("srctl forbidden condition seen");
`else
`define SRCTL_ASSERT(lbl, clk, rst, prop)
`define SRCTL_NEVER(lbl, clk, rst, expr)
`endif

`endif

[src/srctl_pkg.sv]
// Shared types, codes and constants of the sunshade roll controller.
// Depends on nothing; every module file refers to it by scoped names.
package srctl_pkg;

   // input item kinds
   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_SENSOR  = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // command codes
   localparam logic [7:0] CMD_TOGGLE     = 8'd2;
   localparam logic [7:0] CMD_EXTEND     = 8'd5;
   localparam logic [7:0] CMD_ROLL_IN    = 8'd6;
   localparam logic [7:0] CMD_TEMP_UP    = 8'd7;
   localparam logic [7:0] CMD_TEMP_DOWN  = 8'd8;
   localparam logic [7:0] CMD_LIGHT_UP   = 8'd9;
   localparam logic [7:0] CMD_LIGHT_DOWN = 8'd10;

   // report kinds
   localparam logic [1:0] KIND_MODE  = 2'd0;
   localparam logic [1:0] KIND_STATE = 2'd1;
   localparam logic [1:0] KIND_ECHO  = 2'd2;

   // roll states
   localparam logic [1:0] ROLL_IN       = 2'd0;
   localparam logic [1:0] ROLL_EXTENDED = 2'd1;
   localparam logic [1:0] ROLL_MOVING   = 2'd2;

   // lamp bit positions
   localparam int LAMP_RED    = 0;
   localparam int LAMP_YELLOW = 1;
   localparam int LAMP_GREEN  = 2;

   // ceilings
   localparam logic [9:0]  TEMP_CEIL_RESET  = 10'd15;
   localparam logic [9:0]  TEMP_CEIL_MAX    = 10'd1000;
   localparam logic [9:0]  TEMP_CEIL_MIN    = 10'd2;
   localparam logic [9:0]  TEMP_CEIL_STEP   = 10'd2;
   localparam logic [10:0] LIGHT_CEIL_RESET = 11'd800;
   localparam logic [10:0] LIGHT_CEIL_MAX   = 11'd1020;
   localparam logic [10:0] LIGHT_CEIL_MIN   = 11'd25;
   localparam logic [10:0] LIGHT_CEIL_STEP  = 11'd25;

   // temperature test: raw*500 <= (ceiling+50)*1024
   localparam logic [18:0] TEMP_SCALE  = 19'd500;
   localparam logic [20:0] TEMP_OFFSET = 21'd50;
   localparam int          TEMP_SHIFT  = 10;

   localparam logic [7:0] DISAGREE_MAX = 8'd255;

   // configuration registers
   localparam int         CSR_ADDR_W          = 4;
   localparam logic [1:0] REG_DECISION_PERIOD = 2'd0;
   localparam logic [1:0] REG_ROLL_TIME       = 2'd1;
   localparam logic [1:0] REG_CONFIRM         = 2'd2;
   localparam logic [15:0] DECISION_PERIOD_RESET = 16'd500;
   localparam logic [15:0] ROLL_TIME_RESET       = 16'd500;
   localparam logic [7:0]  CONFIRM_RESET         = 8'd2;

   // result queue
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);

   typedef struct packed {
      logic [15:0] decision_period;
      logic [15:0] roll_time;
      logic [7:0]  confirm;
   } srctl_cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] value;
      logic       red;
      logic       yellow;
      logic       green;
      logic       last;
   } srctl_rsp_type;

   typedef struct packed {
      logic [1:0]    n;
      srctl_rsp_type e0;
      srctl_rsp_type e1;
   } srctl_push_type;

endpackage

[src/sunshade_roll_controller_core.sv]
// Sunshade roll controller: one input item (command, sensor sample or 10 ms
// tick) is taken per cycle while the queue has room and gives zero to two
// reports. An item waits in the input register until the queue has room;
// there its state update runs and its reports are registered into a
// four-entry result queue, from which they are offered. The result port moves
// one report per cycle while rsp_ready is high, so sustained rate is one item
// per cycle for items with at most one report; items with two fill the queue
// faster than it drains, and the input stalls when the queue holds more than
// two reports. Configuration takes effect on the next item.
module sunshade_roll_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [7:0]                         req_command,
   input  logic [9:0]                         req_light_sample,
   input  logic [9:0]                         req_temp_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_report_kind,
   output logic [3:0]                         rsp_report_value,
   output logic                               rsp_red_led,
   output logic                               rsp_yellow_led,
   output logic                               rsp_green_led,
   output logic                               rsp_last_report,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srctl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   srctl_pkg::srctl_cfg_type  cfg;
   srctl_pkg::srctl_push_type push;
   srctl_pkg::srctl_rsp_type  head;
   logic                      room;

   srctl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srctl_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_command      (req_command),
      .req_light_sample (req_light_sample),
      .req_temp_sample  (req_temp_sample),
      .room             (room),
      .push             (push)
   );

   srctl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_report_kind  = head.kind;
   assign rsp_report_value = head.value;
   assign rsp_red_led      = head.red;
   assign rsp_yellow_led   = head.yellow;
   assign rsp_green_led    = head.green;
   assign rsp_last_report  = head.last;

endmodule

[src/srctl_csr.sv]
// APB-style configuration registers of the sunshade roll controller.
// Depends on srctl_pkg.
module srctl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srctl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output srctl_pkg::srctl_cfg_type           cfg
);

   logic [15:0] period_ff, period_in;
   logic [15:0] roll_ff, roll_in;
   logic [7:0]  confirm_ff, confirm_in;
   logic        wr;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      period_in  = period_ff;
      roll_in    = roll_ff;
      confirm_in = confirm_ff;
      if (wr) begin
         unique case (idx)
            srctl_pkg::REG_DECISION_PERIOD: period_in  = csr_pwdata[15:0];
            srctl_pkg::REG_ROLL_TIME:       roll_in    = csr_pwdata[15:0];
            srctl_pkg::REG_CONFIRM:         confirm_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         srctl_pkg::REG_DECISION_PERIOD: csr_prdata = {16'd0, period_ff};
         srctl_pkg::REG_ROLL_TIME:       csr_prdata = {16'd0, roll_ff};
         srctl_pkg::REG_CONFIRM:         csr_prdata = {24'd0, confirm_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= srctl_pkg::DECISION_PERIOD_RESET;
         roll_ff    <= srctl_pkg::ROLL_TIME_RESET;
         confirm_ff <= srctl_pkg::CONFIRM_RESET;
      end else begin
         period_ff  <= period_in;
         roll_ff    <= roll_in;
         confirm_ff <= confirm_in;
      end
   end

   assign cfg.decision_period = period_ff;
   assign cfg.roll_time       = roll_ff;
   assign cfg.confirm         = confirm_ff;

endmodule

[src/srctl_engine.sv]
// Input register, controller state and the per-item update logic.
// Depends on srctl_pkg and the assertion macro header.
`include "sunshade_roll_controller_core_defines.svh"

module srctl_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  srctl_pkg::srctl_cfg_type   cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic [7:0]                 req_command,
   input  logic [9:0]                 req_light_sample,
   input  logic [9:0]                 req_temp_sample,
   input  logic                       room,
   output srctl_pkg::srctl_push_type  push
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] op_ff;
   logic [7:0] cmd_ff;
   logic [9:0] light_ff, temp_ff;
   logic       accept, proc;

   // controller state
   logic        mm_ff, mm_in;
   logic [1:0]  rs_ff, rs_in;
   logic        ts_ff, ts_in;
   logic [7:0]  dis_ff, dis_in;
   logic [9:0]  tc_ff, tc_in;
   logic [10:0] lc_ff, lc_in;
   logic [9:0]  sl_ff, sl_in;
   logic [9:0]  st_ff, st_in;
   logic [15:0] dc_ff, dc_in;
   logic [15:0] rc_ff, rc_in;
   logic        rto_ff, rto_in;
   logic [2:0]  lamp_ff, lamp_in;

   logic [20:0] temp_lhs, temp_rhs;
   logic        cool, want;
   logic [1:0]  n;
   logic [1:0]  k0, k1;
   logic [3:0]  v0, v1;

   assign proc      = in_valid_ff & room;
   assign req_ready = ~in_valid_ff | proc;
   assign accept    = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   assign temp_lhs = {2'd0, {9'd0, st_ff} * srctl_pkg::TEMP_SCALE};
   assign temp_rhs = ({11'd0, tc_ff} + srctl_pkg::TEMP_OFFSET) << srctl_pkg::TEMP_SHIFT;
   assign cool     = temp_lhs <= temp_rhs;
   assign want     = ({1'b0, sl_ff} >= lc_ff) & ~cool;

   always_comb begin
      mm_in   = mm_ff;
      rs_in   = rs_ff;
      ts_in   = ts_ff;
      dis_in  = dis_ff;
      tc_in   = tc_ff;
      lc_in   = lc_ff;
      sl_in   = sl_ff;
      st_in   = st_ff;
      dc_in   = dc_ff;
      rc_in   = rc_ff;
      rto_in  = rto_ff;
      lamp_in = lamp_ff;
      n  = 2'd0;
      k0 = srctl_pkg::KIND_MODE;
      v0 = 4'd0;
      k1 = srctl_pkg::KIND_MODE;
      v1 = 4'd0;
      if (proc) begin
         case (op_ff)
            srctl_pkg::OP_COMMAND: begin
               case (cmd_ff) inside
                  srctl_pkg::CMD_TOGGLE: begin
                     mm_in = ~mm_ff;
                     n  = 2'd1;
                     k0 = srctl_pkg::KIND_MODE;
                     v0 = {3'd0, ~mm_ff};
                  end
                  srctl_pkg::CMD_EXTEND, srctl_pkg::CMD_ROLL_IN: begin
                     mm_in   = 1'b1;
                     ts_in   = (cmd_ff == srctl_pkg::CMD_EXTEND);
                     rs_in   = srctl_pkg::ROLL_MOVING;
                     lamp_in = {ts_in, 1'b1, ~ts_in};
                     rto_in  = 1'b1;
                     rc_in   = cfg.roll_time;
                     n  = 2'd2;
                     k0 = srctl_pkg::KIND_MODE;
                     v0 = 4'd1;
                     k1 = srctl_pkg::KIND_STATE;
                     v1 = {2'd0, srctl_pkg::ROLL_MOVING};
                  end
                  srctl_pkg::CMD_TEMP_UP: begin
                     if (tc_ff < srctl_pkg::TEMP_CEIL_MAX) begin
                        tc_in = tc_ff + srctl_pkg::TEMP_CEIL_STEP;
                        n  = 2'd1;
                        k0 = srctl_pkg::KIND_ECHO;
                        v0 = cmd_ff[3:0];
                     end
                  end
                  srctl_pkg::CMD_TEMP_DOWN: begin
                     if (tc_ff > srctl_pkg::TEMP_CEIL_MIN) begin
                        tc_in = tc_ff - srctl_pkg::TEMP_CEIL_STEP;
                        n  = 2'd1;
                        k0 = srctl_pkg::KIND_ECHO;
                        v0 = cmd_ff[3:0];
                     end
                  end
                  srctl_pkg::CMD_LIGHT_UP: begin
                     if (lc_ff < srctl_pkg::LIGHT_CEIL_MAX) begin
                        lc_in = lc_ff + srctl_pkg::LIGHT_CEIL_STEP;
                        n  = 2'd1;
                        k0 = srctl_pkg::KIND_ECHO;
                        v0 = cmd_ff[3:0];
                     end
                  end
                  srctl_pkg::CMD_LIGHT_DOWN: begin
                     if (lc_ff > srctl_pkg::LIGHT_CEIL_MIN) begin
                        lc_in = lc_ff - srctl_pkg::LIGHT_CEIL_STEP;
                        n  = 2'd1;
                        k0 = srctl_pkg::KIND_ECHO;
                        v0 = cmd_ff[3:0];
                     end
                  end
                  default: ;
               endcase
            end
            srctl_pkg::OP_SENSOR: begin
               sl_in = light_ff;
               st_in = temp_ff;
            end
            srctl_pkg::OP_TICK: begin
               // count down first, then decide, then settle
               if (dc_ff != 16'd0) begin
                  dc_in = dc_ff - 16'd1;
               end
               if (rto_ff && rc_ff != 16'd0) begin
                  rc_in = rc_ff - 16'd1;
               end
               if (dc_in == 16'd0) begin
                  if (!mm_ff && rs_ff != srctl_pkg::ROLL_MOVING) begin
                     if ({1'b0, want} != rs_ff) begin
                        if (dis_ff < srctl_pkg::DISAGREE_MAX) begin
                           dis_in = dis_ff + 8'd1;
                        end
                     end else begin
                        dis_in = 8'd0;
                     end
                     if (dis_in >= cfg.confirm) begin
                        ts_in   = want;
                        rs_in   = srctl_pkg::ROLL_MOVING;
                        lamp_in = {want, 1'b1, ~want};
                        rto_in  = 1'b1;
                        rc_in   = cfg.roll_time;
                        dis_in  = 8'd0;
                        n  = 2'd1;
                        k0 = srctl_pkg::KIND_STATE;
                        v0 = {2'd0, srctl_pkg::ROLL_MOVING};
                     end
                  end
                  dc_in = cfg.decision_period;
               end
               if (rto_in && rc_in == 16'd0) begin
                  rs_in = {1'b0, ts_in};
                  lamp_in[srctl_pkg::LAMP_YELLOW] = 1'b0;
                  rto_in = 1'b0;
                  rc_in  = cfg.roll_time;
                  if (n == 2'd0) begin
                     k0 = srctl_pkg::KIND_STATE;
                     v0 = {2'd0, rs_in};
                  end else begin
                     k1 = srctl_pkg::KIND_STATE;
                     v1 = {2'd0, rs_in};
                  end
                  n = n + 2'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // lamps in every result show the level after the whole item
   always_comb begin
      push.n         = n;
      push.e0.kind   = k0;
      push.e0.value  = v0;
      push.e0.red    = lamp_in[srctl_pkg::LAMP_RED];
      push.e0.yellow = lamp_in[srctl_pkg::LAMP_YELLOW];
      push.e0.green  = lamp_in[srctl_pkg::LAMP_GREEN];
      push.e0.last   = (n == 2'd1);
      push.e1.kind   = k1;
      push.e1.value  = v1;
      push.e1.red    = lamp_in[srctl_pkg::LAMP_RED];
      push.e1.yellow = lamp_in[srctl_pkg::LAMP_YELLOW];
      push.e1.green  = lamp_in[srctl_pkg::LAMP_GREEN];
      push.e1.last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         cmd_ff   <= req_command;
         light_ff <= req_light_sample;
         temp_ff  <= req_temp_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mm_ff       <= 1'b0;
         rs_ff       <= srctl_pkg::ROLL_IN;
         ts_ff       <= 1'b0;
         dis_ff      <= 8'd0;
         tc_ff       <= srctl_pkg::TEMP_CEIL_RESET;
         lc_ff       <= srctl_pkg::LIGHT_CEIL_RESET;
         sl_ff       <= 10'd0;
         st_ff       <= 10'd0;
         dc_ff       <= 16'd0;
         rc_ff       <= 16'd0;
         rto_ff      <= 1'b0;
         lamp_ff     <= 3'b001;
      end else begin
         in_valid_ff <= in_valid_in;
         mm_ff       <= mm_in;
         rs_ff       <= rs_in;
         ts_ff       <= ts_in;
         dis_ff      <= dis_in;
         tc_ff       <= tc_in;
         lc_ff       <= lc_in;
         sl_ff       <= sl_in;
         st_ff       <= st_in;
         dc_ff       <= dc_in;
         rc_ff       <= rc_in;
         rto_ff      <= rto_in;
         lamp_ff     <= lamp_in;
      end
   end

   `SRCTL_ASSERT(a_yellow_while_rolling, clock, reset,
                 lamp_ff[srctl_pkg::LAMP_YELLOW] == (rs_ff == srctl_pkg::ROLL_MOVING))
   `SRCTL_ASSERT(a_timer_while_rolling, clock, reset,
                 rto_ff == (rs_ff == srctl_pkg::ROLL_MOVING))
   `SRCTL_ASSERT(a_red_or_green, clock, reset,
                 $onehot({lamp_ff[srctl_pkg::LAMP_RED], lamp_ff[srctl_pkg::LAMP_GREEN]}))

endmodule

[src/srctl_outq.sv]
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on srctl_pkg and the assertion macro header.
`include "sunshade_roll_controller_core_defines.svh"

module srctl_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  srctl_pkg::srctl_push_type  push,
   output logic                       room,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output srctl_pkg::srctl_rsp_type   head
);

   localparam int CW = srctl_pkg::OQ_AW + 1;

   srctl_pkg::srctl_rsp_type entry_ff [srctl_pkg::OQ_DEPTH];
   logic [srctl_pkg::OQ_AW-1:0] rd_ff, rd_in, wr_ff, wr_in, wr_next;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        pop;

   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid & rsp_ready;
   assign head      = entry_ff[rd_ff];
   // room for a two-result item, whether or not a transfer leaves this cycle
   assign room      = (cnt_ff <= CW'(srctl_pkg::OQ_DEPTH - 2));
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      wr_in  = wr_ff + push.n[srctl_pkg::OQ_AW-1:0];
      cnt_in = cnt_ff + CW'(push.n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         entry_ff[wr_ff] <= push.e0;
      end
      if (push.n == 2'd2) begin
         entry_ff[wr_next] <= push.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   `SRCTL_ASSERT(a_cnt_range, clock, reset, cnt_ff <= CW'(srctl_pkg::OQ_DEPTH))
   `SRCTL_NEVER(a_push_without_room, clock, reset, (push.n != 2'd0) && !room)

endmodule
